// ===== rtl/grv_pkg.sv =====
package grv_pkg;

  localparam int unsigned LON_W_DEF  = 48;
  localparam int unsigned WIND_W_DEF = 16;
  localparam int unsigned LAT_W      = 32;
  localparam int unsigned TOL_W      = 20;
  localparam int unsigned SIDE_W     = 2;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CNT_W      = 3;

  // angles are 2^-32 turn per unit: half turn is bit 31, quarter turn is bit 30
  localparam int unsigned FRAC_W = 32;

  localparam int unsigned MID_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 4;

  localparam logic [CNT_W-1:0] VCOUNT_MIN = 3'd3;
  localparam logic [CNT_W-1:0] VCOUNT_SAT = 3'd4;

  localparam logic signed [LAT_W-1:0] LAT_MAX = 32'sh4000_0000;
  localparam logic signed [LAT_W-1:0] LAT_MIN = -32'sh4000_0000;

  typedef enum logic [1:0] {
    EDGE_NONE     = 2'd0,
    EDGE_AMBIG    = 2'd1,
    EDGE_NONCANON = 2'd2
  } edge_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_NONE     = 3'd0,
    ST_TOO_FEW  = 3'd1,
    ST_NONCANON = 3'd2,
    ST_LATITUDE = 3'd3,
    ST_AMBIG    = 3'd4,
    ST_WINDING  = 3'd5
  } status_e;

  typedef enum logic [SIDE_W-1:0] {
    SIDE_UNSPEC  = 2'd0,
    SIDE_LEFT    = 2'd1,
    SIDE_RIGHT   = 2'd2,
    SIDE_INVALID = 2'd3
  } side_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_TOL = 1'b0,
    CFG_WIND_TOL = 1'b1
  } cfg_reg_e;

  // ring outcome known at the front; decided=0 leaves it to the closing checks
  typedef struct packed {
    logic    decided;
    status_e status;
    logic    side_unspec;
  } grv_pre_t;

  function automatic status_e edge_status(edge_e e);
    status_e s;
    unique case (e)
      EDGE_AMBIG:    s = ST_AMBIG;
      EDGE_NONCANON: s = ST_NONCANON;
      default:       s = ST_NONE;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/grv_queue.sv =====
module grv_queue
  import grv_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic                       full_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned QC_W  = $clog2(DEPTH+1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [QC_W-1:0]  FULL_CNT = QC_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QC_W-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == FULL_CNT);
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QC_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/grv_edge_chk.sv =====
module grv_edge_chk
  import grv_pkg::*;
#(
  parameter int unsigned W = LON_W_DEF
) (
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  input  logic [TOL_W-1:0]    tol_i,
  output edge_e               fault_o
);

  localparam logic [W:0] HALF = (W+1)'(1) << (FRAC_W - 1);

  logic signed [W:0] diff;
  logic [W:0]        mag, lo, hi;
  logic              ambig, beyond;

  assign diff = {a_i[W-1], a_i} - {b_i[W-1], b_i};
  assign mag  = diff[W] ? (W+1)'(-diff) : (W+1)'(diff);
  assign lo   = HALF - (W+1)'(tol_i);
  assign hi   = HALF + (W+1)'(tol_i);

  // ||d| - half| <= tol is the same as lo <= |d| <= hi
  assign ambig  = (mag >= lo) && (mag <= hi);
  assign beyond = (mag > HALF);

  always_comb begin
    priority if (ambig) begin
      fault_o = EDGE_AMBIG;
    end else if (beyond) begin
      fault_o = EDGE_NONCANON;
    end else begin
      fault_o = EDGE_NONE;
    end
  end

endmodule

// ===== rtl/grv_front.sv =====
module grv_front
  import grv_pkg::*;
#(
  parameter int unsigned LW = LON_W_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic signed [LW-1:0]    lon_i,
  input  logic signed [LAT_W-1:0] lat_i,
  input  logic                    last_i,
  input  logic [SIDE_W-1:0]       side_i,
  input  logic [TOL_W-1:0]        half_tol_i,
  output logic                    rec_push_o,
  output grv_pre_t                pre_o,
  output logic signed [LW-1:0]    first_lon_o
);

  localparam logic signed [LW-1:0] HALF_S     = LW'(1) << (FRAC_W - 1);
  localparam logic signed [LW-1:0] NEG_HALF_S = -HALF_S;

  logic [CNT_W-1:0]        count_q, count_d;
  edge_e                   edge_fault_q, edge_fault_d, edge_cur;
  logic                    lat_fault_q, lat_fault_d;
  logic signed [LW-1:0]    first_lon_q, prev_lon_q, first_lon_eff;
  logic signed [LAT_W-1:0] first_lat_q, first_lat_eff;
  logic                    is_first, lat_bad, first_ok, repeat_close;

  grv_edge_chk #(.W(LW)) u_edge (
    .a_i     (lon_i),
    .b_i     (prev_lon_q),
    .tol_i   (half_tol_i),
    .fault_o (edge_cur)
  );

  assign is_first      = (count_q == '0);
  assign first_lon_eff = is_first ? lon_i : first_lon_q;
  assign first_lat_eff = is_first ? lat_i : first_lat_q;
  assign lat_bad       = (lat_i < LAT_MIN) || (lat_i > LAT_MAX);

  assign count_d     = (count_q == VCOUNT_SAT) ? count_q : count_q + CNT_W'(1);
  assign lat_fault_d = lat_fault_q | lat_bad;
  assign edge_fault_d = (!is_first && edge_fault_q == EDGE_NONE) ? edge_cur : edge_fault_q;

  assign first_ok = (first_lon_eff > NEG_HALF_S) && (first_lon_eff <= HALF_S);

  // closing vertex equals the first when the longitude differs by whole turns
  assign repeat_close = (count_d == VCOUNT_SAT) && (lat_i == first_lat_eff) &&
                        (lon_i[FRAC_W-1:0] == first_lon_eff[FRAC_W-1:0]);

  assign rec_push_o  = accept_i && last_i;
  assign first_lon_o = first_lon_eff;

  always_comb begin
    pre_o.decided     = 1'b1;
    pre_o.side_unspec = (side_i == SIDE_UNSPEC);
    priority if (count_d < VCOUNT_MIN) begin
      pre_o.status = ST_TOO_FEW;
    end else if (side_i == SIDE_INVALID) begin
      pre_o.status = ST_NONCANON;
    end else if (lat_fault_d) begin
      pre_o.status = ST_LATITUDE;
    end else if (!first_ok) begin
      pre_o.status = ST_NONCANON;
    end else if (repeat_close) begin
      pre_o.status = ST_NONCANON;
    end else if (edge_fault_d != EDGE_NONE) begin
      pre_o.status = edge_status(edge_fault_d);
    end else begin
      pre_o.decided = 1'b0;
      pre_o.status  = ST_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      lat_fault_q  <= 1'b0;
      edge_fault_q <= EDGE_NONE;
    end else if (accept_i) begin
      if (last_i) begin
        count_q      <= '0;
        lat_fault_q  <= 1'b0;
        edge_fault_q <= EDGE_NONE;
      end else begin
        count_q      <= count_d;
        lat_fault_q  <= lat_fault_d;
        edge_fault_q <= edge_fault_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      prev_lon_q  <= lon_i;
      first_lon_q <= first_lon_eff;
      first_lat_q <= first_lat_eff;
    end
  end

endmodule

// ===== rtl/grv_back.sv =====
module grv_back
  import grv_pkg::*;
#(
  parameter int unsigned LW = LON_W_DEF,
  parameter int unsigned WW = WIND_W_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rec_empty_i,
  input  grv_pre_t             rec_pre_i,
  input  logic signed [LW-1:0] rec_closing_i,
  input  logic signed [LW-1:0] rec_last_lon_i,
  input  logic signed [LW-1:0] rec_first_lon_i,
  input  logic signed [WW-1:0] rec_winding_i,
  input  logic [TOL_W-1:0]     half_tol_i,
  input  logic [TOL_W-1:0]     wind_tol_i,
  output logic                 rec_pop_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output logic [STATUS_W-1:0]  status_o
);

  localparam int unsigned SPAN_W = LW + 1;
  localparam int unsigned PROD_W = WW + FRAC_W;
  localparam int unsigned MW     = ((SPAN_W > PROD_W) ? SPAN_W : PROD_W) + 1;
  localparam int unsigned OC_W   = $clog2(OUT_DEPTH + 1);

  logic                    va_q;
  grv_pre_t                pre_a_q;
  edge_e                   edge_a_q, edge_close;
  logic signed [SPAN_W-1:0] span_a_q;
  logic signed [WW-1:0]    wind_a_q;

  logic signed [MW-1:0]    span_ext, wind_ext, mis, tol_s;
  logic                    mis_ok;
  status_e                 status_b;
  logic [OC_W-1:0]         out_cnt;
  logic [OC_W:0]           occupancy;

  grv_edge_chk #(.W(LW)) u_close_edge (
    .a_i     (rec_closing_i),
    .b_i     (rec_last_lon_i),
    .tol_i   (half_tol_i),
    .fault_o (edge_close)
  );

  // a ring is taken only when the result queue has room for it and the one in flight
  assign occupancy = (OC_W+1)'(out_cnt) + (OC_W+1)'(va_q);
  assign rec_pop_o = !rec_empty_i && (occupancy < (OC_W+1)'(OUT_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= rec_pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_pop_o) begin
      pre_a_q  <= rec_pre_i;
      edge_a_q <= edge_close;
      span_a_q <= {rec_closing_i[LW-1], rec_closing_i} -
                  {rec_first_lon_i[LW-1], rec_first_lon_i};
      wind_a_q <= rec_winding_i;
    end
  end

  // |span - winding * full turn| <= tol, checked as two signed bounds
  assign span_ext = MW'(span_a_q);
  assign wind_ext = MW'(wind_a_q) <<< FRAC_W;
  assign mis      = span_ext - wind_ext;
  assign tol_s    = signed'(MW'(wind_tol_i));
  assign mis_ok   = (mis <= tol_s) && (mis >= -tol_s);

  always_comb begin
    priority if (pre_a_q.decided) begin
      status_b = pre_a_q.status;
    end else if (edge_a_q != EDGE_NONE) begin
      status_b = edge_status(edge_a_q);
    end else if (!mis_ok) begin
      status_b = ST_NONCANON;
    end else if (wind_a_q != '0 && pre_a_q.side_unspec) begin
      status_b = ST_WINDING;
    end else begin
      status_b = ST_NONE;
    end
  end

  grv_queue #(.WIDTH(STATUS_W), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (va_q),
    .wdata_i (status_b),
    .pop_i   (pop_i),
    .rdata_o (status_o),
    .empty_o (empty_o),
    .full_o  (),
    .count_o (out_cnt)
  );

endmodule

// ===== rtl/geodetic_ring_validator.sv =====
// Ring vertex checker. One vertex is accepted per clock (push while full is low);
// vertices are checked as they stream in, and the vertex flagged is_last closes the
// ring and yields exactly one status through the ring queue, the closing-check
// register and the result queue; other vertices yield nothing. Rings queue
// between the vertex front end and the closing-check back end (two rings deep) and
// results queue four deep, so full rises only when both queues back up behind an
// unpopped result. Tolerance registers are written through the cfg port (always
// ready) and should only change while no ring is in progress.
module geodetic_ring_validator
  import grv_pkg::*;
#(
  parameter int unsigned LONGITUDE_WIDTH = LON_W_DEF,
  parameter int unsigned WINDING_WIDTH   = WIND_W_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic signed [LONGITUDE_WIDTH-1:0] vertex_longitude_i,
  input  logic signed [LAT_W-1:0]           vertex_latitude_i,
  input  logic                              is_last_i,
  input  logic signed [LONGITUDE_WIDTH-1:0] closing_longitude_i,
  input  logic signed [WINDING_WIDTH-1:0]   winding_turns_i,
  input  logic [SIDE_W-1:0]                 interior_side_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [STATUS_W-1:0]               status_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]              cfg_index_i,
  input  logic [TOL_W-1:0]                  cfg_data_i
);

  localparam int unsigned LW    = LONGITUDE_WIDTH;
  localparam int unsigned WW    = WINDING_WIDTH;
  localparam int unsigned PRE_W = $bits(grv_pre_t);
  localparam int unsigned REC_W = PRE_W + 3 * LW + WW;

  logic [TOL_W-1:0]     half_tol_q, wind_tol_q;
  logic                 accept, rec_push, rec_pop, mid_empty, mid_full;
  grv_pre_t             front_pre, mid_pre;
  logic signed [LW-1:0] front_first, mid_closing, mid_last, mid_first;
  logic signed [WW-1:0] mid_wind;
  logic [REC_W-1:0]     mid_wdata, mid_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_tol_q <= '0;
      wind_tol_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_HALF_TOL: half_tol_q <= cfg_data_i;
        CFG_WIND_TOL: wind_tol_q <= cfg_data_i;
      endcase
    end
  end

  assign full   = mid_full;
  assign accept = push && !mid_full;

  grv_front #(.LW(LW)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .lon_i       (vertex_longitude_i),
    .lat_i       (vertex_latitude_i),
    .last_i      (is_last_i),
    .side_i      (interior_side_i),
    .half_tol_i  (half_tol_q),
    .rec_push_o  (rec_push),
    .pre_o       (front_pre),
    .first_lon_o (front_first)
  );

  assign mid_wdata = {front_pre, closing_longitude_i, vertex_longitude_i, front_first,
                      winding_turns_i};
  assign {mid_pre, mid_closing, mid_last, mid_first, mid_wind} = mid_rdata;

  grv_queue #(.WIDTH(REC_W), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .wdata_i (mid_wdata),
    .pop_i   (rec_pop),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty),
    .full_o  (mid_full),
    .count_o ()
  );

  grv_back #(.LW(LW), .WW(WW)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rec_empty_i     (mid_empty),
    .rec_pre_i       (mid_pre),
    .rec_closing_i   (mid_closing),
    .rec_last_lon_i  (mid_last),
    .rec_first_lon_i (mid_first),
    .rec_winding_i   (mid_wind),
    .half_tol_i      (half_tol_q),
    .wind_tol_i      (wind_tol_q),
    .rec_pop_o       (rec_pop),
    .pop_i           (pop),
    .empty_o         (empty),
    .status_o        (status_o)
  );

  a_pop_has_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_pop |-> !mid_empty)
    else $error("back end took a ring from an empty queue");

  a_push_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_push |-> (accept && is_last_i))
    else $error("ring record pushed without an accepted last vertex");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_push |=> !mid_empty)
    else $error("pushed ring missing from queue");

endmodule
